FILE: design/tosl_pkg.sv
`timescale 1ns / 1ps

package tosl_pkg;

    localparam int TIME_W  = 64;
    localparam int GATE_W  = 8;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ARRIVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_EARLY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // contents of one list cell
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] time_val;
        logic [GATE_W-1:0] gate;
    } t_cell_data;

    // control broadcast to every cell
    typedef struct packed {
        logic              cmp_en;
        logic              upd_en;
        logic              do_add;
        logic              do_remove;
        logic              match_time;
        logic [TIME_W-1:0] key_time;
        logic [GATE_W-1:0] key_gate;
    } t_cell_ctl;

endpackage

FILE: design/tosl_req_if.sv
`timescale 1ns / 1ps

interface tosl_req_if;
    import tosl_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] event_time;
    logic [GATE_W-1:0] gate_index;

    modport source (output valid, output req_type, output event_time, output gate_index,
                    input ready);
    modport sink   (input valid, input req_type, input event_time, input gate_index,
                    output ready);
endinterface

FILE: design/tosl_res_if.sv
`timescale 1ns / 1ps

interface tosl_res_if;
    import tosl_pkg::*;

    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  head_time;
    logic               list_empty;
    logic               must_block;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  status;

    modport source (output valid, output head_time, output list_empty, output must_block,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input head_time, input list_empty, input must_block,
                    input entry_count, input status, output ready);
endinterface

FILE: design/tosl_cell.sv
`timescale 1ns / 1ps

module tosl_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tosl_pkg::t_cell_ctl   i_ctl,
    input  tosl_pkg::t_cell_data  i_prev,
    input  logic                  i_prev_gt,
    input  tosl_pkg::t_cell_data  i_next,
    input  logic                  i_incl,
    output tosl_pkg::t_cell_data  o_data,
    output tosl_pkg::t_cell_data  o_next_data,
    output logic                  o_match,
    output logic                  o_gt,
    output logic                  o_late
);
    import tosl_pkg::*;

    logic              r_valid;
    logic [TIME_W-1:0] r_time;
    logic [GATE_W-1:0] r_gate;
    logic              r_match;
    logic              r_gt;
    logic              r_late;

    t_cell_data        n_data;
    t_cell_data        w_cur;
    logic              w_eq_gate;
    logic              w_eq_time;

    assign w_cur     = '{valid: r_valid, time_val: r_time, gate: r_gate};
    assign w_eq_gate = (r_gate == i_ctl.key_gate);
    assign w_eq_time = (r_time == i_ctl.key_time);

    // insert, shift toward the tail, or close the gap left by a removal
    always_comb begin
        n_data = w_cur;
        if (i_ctl.upd_en) begin
            if (i_ctl.do_add && !r_gt) begin
                if (i_prev_gt) begin
                    n_data = '{valid: 1'b1, time_val: i_ctl.key_time, gate: i_ctl.key_gate};
                end else begin
                    n_data = i_prev;
                end
            end else if (i_ctl.do_remove && i_incl) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_data.time_val;
        r_gate <= n_data.gate;
        if (i_ctl.cmp_en) begin
            r_gt    <= r_valid && (i_ctl.key_time > r_time);
            r_late  <= r_valid && (r_time > i_ctl.key_time);
            r_match <= r_valid && w_eq_gate && (!i_ctl.match_time || w_eq_time);
        end
    end

    assign o_data      = w_cur;
    assign o_next_data = n_data;
    assign o_match     = r_match;
    assign o_gt        = r_gt;
    assign o_late      = r_late;

endmodule

FILE: design/tosl_prefix.sv
`timescale 1ns / 1ps

module tosl_prefix #(
    parameter int N = 16
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_incl
);
    localparam int LVLS = (N > 1) ? $clog2(N) : 1;

    logic [LVLS:0][N-1:0] w_lvl;

    assign w_lvl[0] = i_bits;

    // log-depth inclusive prefix or
    genvar l, i;
    generate
        for (l = 0; l < LVLS; l++) begin : g_lvl
            for (i = 0; i < N; i++) begin : g_bit
                if (i >= (1 << l)) begin : g_comb
                    assign w_lvl[l+1][i] = w_lvl[l][i] | w_lvl[l][i-(1<<l)];
                end else begin : g_pass
                    assign w_lvl[l+1][i] = w_lvl[l][i];
                end
            end
        end
    endgenerate

    assign o_incl = w_lvl[LVLS];

endmodule

FILE: design/time_ordered_syncpoint_list_unit.sv
`timescale 1ns / 1ps

// time-ordered sync point list: a row of LIST_DEPTH cells, cell 0 holding the
// earliest (time, gate) entry and occupied cells always packed toward cell 0.
// each request passes its accept, compare and update edges in turn: the accept
// edge latches the request, the compare edge has every cell compare its entry
// against the request key in parallel (64-bit greater/equal plus gate equal),
// and the update edge uses a log-depth prefix-or over the cell match bits to
// find the earliest match, then every cell inserts, shifts one place from its
// neighbor or keeps its entry, and the result register is loaded. the next
// request is taken in the cycle after the update, so one request at a time is
// in flight. if the result register is still occupied when an update is due,
// the update waits for it to drain, and no new request is taken meanwhile.
// head_time is all ones on an empty list and list_empty tells that apart from
// a stored all-ones time. a full list drops an add with status full; removals
// of a missing entry report no match.
// entry storage has no reset, only the per-cell occupancy bits are cleared.
module time_ordered_syncpoint_list_unit #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tosl_req_if.sink    i_req,
    tosl_res_if.source  o_res
);
    import tosl_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state             r_state;
    logic [REQ_W-1:0]   r_req_type;
    logic [TIME_W-1:0]  r_time;
    logic [GATE_W-1:0]  r_gate;
    logic [CW-1:0]      r_count;

    // result register
    logic               r_out_valid;
    logic [TIME_W-1:0]  r_out_head;
    logic               r_out_empty;
    logic               r_out_block;
    logic [COUNT_W-1:0] r_out_count;
    logic [STAT_W-1:0]  r_out_status;

    t_cell_ctl          w_ctl;
    t_cell_data         w_data  [LIST_DEPTH];
    t_cell_data         w_ndata [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_match;
    logic [LIST_DEPTH-1:0] w_gt;
    logic [LIST_DEPTH-1:0] w_late;
    logic [LIST_DEPTH-1:0] w_incl;
    logic [LIST_DEPTH-1:0] w_first;

    logic               w_accept;
    logic               w_commit;
    logic               w_full;
    logic               w_found;
    logic               w_early;
    logic               w_is_add;
    logic               w_is_rm;
    logic [CW-1:0]      n_count;
    logic [CW+COUNT_W-1:0] w_count_ext;
    logic [STAT_W-1:0]  w_status;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || o_res.ready);
    assign w_full   = (r_count == CW'(LIST_DEPTH));
    assign w_is_add = (r_req_type == REQ_ADD);
    assign w_is_rm  = (r_req_type == REQ_CANCEL) || (r_req_type == REQ_ARRIVE);

    assign i_req.ready = (r_state == S_IDLE);

    // broadcast control to the cell row
    always_comb begin
        w_ctl.cmp_en     = (r_state == S_CMP);
        w_ctl.upd_en     = w_commit;
        w_ctl.do_add     = w_is_add && !w_full;
        w_ctl.do_remove  = w_is_rm;
        w_ctl.match_time = (r_req_type == REQ_CANCEL);
        w_ctl.key_time   = r_time;
        w_ctl.key_gate   = r_gate;
    end

    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
            t_cell_data w_prev;
            t_cell_data w_next;
            logic       w_prev_gt;

            if (i == 0) begin : g_head
                assign w_prev    = '0;
                assign w_prev_gt = 1'b1;
            end else begin : g_mid
                assign w_prev    = w_data[i-1];
                assign w_prev_gt = w_gt[i-1];
            end

            if (i == LIST_DEPTH - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_data[i+1];
            end

            tosl_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_prev      (w_prev),
                .i_prev_gt   (w_prev_gt),
                .i_next      (w_next),
                .i_incl      (w_incl[i]),
                .o_data      (w_data[i]),
                .o_next_data (w_ndata[i]),
                .o_match     (w_match[i]),
                .o_gt        (w_gt[i]),
                .o_late      (w_late[i])
            );

            // earliest match is where the inclusive prefix first turns on
            if (i == 0) begin : g_first0
                assign w_first[i] = w_incl[i];
            end else begin : g_firstn
                assign w_first[i] = w_incl[i] && !w_incl[i-1];
            end
        end
    endgenerate

    tosl_prefix #(
        .N (LIST_DEPTH)
    ) u_prefix (
        .i_bits (w_match),
        .o_incl (w_incl)
    );

    assign w_found = w_incl[LIST_DEPTH-1];
    assign w_early = |(w_first & w_late);

    always_comb begin
        n_count = r_count;
        if (w_is_add && !w_full) begin
            n_count = r_count + CW'(1);
        end else if (w_is_rm && w_found) begin
            n_count = r_count - CW'(1);
        end
    end

    // count field keeps the low bits of the count
    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    always_comb begin
        case (r_req_type)
            REQ_ADD:    w_status = w_full ? ST_FULL : ST_OK;
            REQ_CANCEL: w_status = w_found ? ST_OK : ST_NO_MATCH;
            REQ_ARRIVE: w_status = !w_found ? ST_NO_MATCH : (w_early ? ST_EARLY : ST_OK);
            REQ_PROBE:  w_status = ST_OK;
            default:    w_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_accept) begin
            r_req_type <= i_req.req_type;
            r_time     <= i_req.event_time;
            r_gate     <= i_req.gate_index;
        end

        if (w_commit) begin
            r_out_head   <= (n_count == '0) ? '1 : w_ndata[0].time_val;
            r_out_empty  <= (n_count == '0);
            // cell 0 compare is against the current head; empty head never blocks
            r_out_block  <= (r_req_type == REQ_PROBE) && w_gt[0];
            r_out_count  <= w_count_ext[COUNT_W-1:0];
            r_out_status <= w_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.head_time   = r_out_head;
    assign o_res.list_empty  = r_out_empty;
    assign o_res.must_block  = r_out_block;
    assign o_res.entry_count = r_out_count;
    assign o_res.status      = r_out_status;

    // checks: occupancy packed at the head, list sorted, count bounded, full add dropped
    logic [LIST_DEPTH-1:0] w_valid_vec;
    logic [LIST_DEPTH-1:0] w_therm;
    logic [LIST_DEPTH-1:0] w_order_ok;

    generate
        for (i = 0; i < LIST_DEPTH; i++) begin : g_chk
            assign w_valid_vec[i] = w_data[i].valid;
            assign w_therm[i]     = (CW'(i) < r_count);
            if (i == 0) begin : g_o0
                assign w_order_ok[i] = 1'b1;
            end else begin : g_on
                assign w_order_ok[i] = !w_data[i].valid ||
                                       (w_data[i-1].time_val <= w_data[i].time_val);
            end
        end
    endgenerate

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid_vec == w_therm)
        else $error("cell occupancy does not match entry count");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_ok)
        else $error("list not in time order");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_is_add && w_full) |=> (r_count == $past(r_count)))
        else $error("add on full list changed the count");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tosl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int REPORT_LIMIT = 10;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam logic [TIME_W-1:0] NO_TIME = '1;

    // one result item as the list reports it
    typedef struct packed {
        logic [TIME_W-1:0]  head_time;
        logic               list_empty;
        logic               must_block;
        logic [COUNT_W-1:0] entry_count;
        logic [STAT_W-1:0]  status;
    } sync_result_t;

    // shadow of the sorted list plus the results still owed by the block
    class syncpoint_tracker;
        logic [TIME_W-1:0] slot_times[$];
        logic [GATE_W-1:0] slot_gates[$];
        sync_result_t      pending_results[$];
        int                mismatches;

        function logic [TIME_W-1:0] earliest_time();
            return (slot_times.size() > 0) ? slot_times[0] : NO_TIME;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // apply one accepted request to the shadow list and queue its result
        function void note_request(logic [REQ_W-1:0] req, logic [TIME_W-1:0] t,
                                   logic [GATE_W-1:0] g);
            sync_result_t r;
            int           pos;
            r.status     = ST_OK;
            r.must_block = 1'b0;
            pos = 0;
            case (req)
                REQ_ADD: begin
                    if (slot_times.size() >= LIST_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // new entry goes ahead of equal or later times
                        while (pos < slot_times.size() && t > slot_times[pos]) pos++;
                        slot_times.insert(pos, t);
                        slot_gates.insert(pos, g);
                    end
                end
                REQ_CANCEL: begin
                    while (pos < slot_times.size() &&
                           (slot_gates[pos] != g || slot_times[pos] != t)) pos++;
                    if (pos >= slot_times.size()) begin
                        r.status = ST_NO_MATCH;
                    end else begin
                        slot_times.delete(pos);
                        slot_gates.delete(pos);
                    end
                end
                REQ_ARRIVE: begin
                    while (pos < slot_times.size() && slot_gates[pos] != g) pos++;
                    if (pos >= slot_times.size()) begin
                        r.status = ST_NO_MATCH;
                    end else begin
                        // message came in ahead of its sync point
                        if (slot_times[pos] > t) r.status = ST_EARLY;
                        slot_times.delete(pos);
                        slot_gates.delete(pos);
                    end
                end
                default: begin
                    r.must_block = (t > earliest_time());
                end
            endcase
            r.head_time   = earliest_time();
            r.list_empty  = (slot_times.size() == 0);
            r.entry_count = COUNT_W'(slot_times.size());
            pending_results.push_back(r);
        endfunction

        function void report(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        endfunction

        function void check_result(sync_result_t got);
            sync_result_t want;
            if (pending_results.size() == 0) begin
                report("result with no request outstanding, head_time", NO_TIME,
                       got.head_time);
                return;
            end
            want = pending_results.pop_front();
            if (got.head_time !== want.head_time)
                report("head_time", want.head_time, got.head_time);
            if (got.list_empty !== want.list_empty)
                report("list_empty", TIME_W'(want.list_empty), TIME_W'(got.list_empty));
            if (got.must_block !== want.must_block)
                report("must_block", TIME_W'(want.must_block), TIME_W'(got.must_block));
            if (got.entry_count !== want.entry_count)
                report("entry_count", TIME_W'(want.entry_count), TIME_W'(got.entry_count));
            if (got.status !== want.status)
                report("status", TIME_W'(want.status), TIME_W'(got.status));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    // idle_on enables random bursts on both sides, hold_off_req asks the
    // receiver for one long stall so the list backs up into the request side
    bit idle_on;
    bit hold_off_req;

    syncpoint_tracker tracker;

    tosl_req_if req_if ();
    tosl_res_if res_if ();

    time_ordered_syncpoint_list_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    always #2 i_clk = ~i_clk;

    // hard stop well beyond the slowest legal run
    initial begin
        #2ms;
        $display("testbench: done, errors");
        $finish;
    end

    // monitor: requests are noted before results, a result never comes in the
    // same cycle as its own request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                tracker.note_request(req_if.req_type, req_if.event_time, req_if.gate_index);
            if (res_if.valid && res_if.ready)
                tracker.check_result('{res_if.head_time, res_if.list_empty,
                                       res_if.must_block, res_if.entry_count,
                                       res_if.status});
        end
    end

    // result receiver: random stall bursts, or one long hold when asked
    initial begin
        res_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    function automatic logic [TIME_W-1:0] pick_time();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return NO_TIME;
        // small times give plenty of ties and near misses
        if (roll < 6) return TIME_W'($urandom_range(0, 31));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [GATE_W-1:0] pick_gate();
        if ($urandom_range(0, 4) != 0) return GATE_W'($urandom_range(0, 7));
        return GATE_W'($urandom_range(0, 255));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance;
    // valid stays high so back-to-back items need no second assignment
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                             input logic [GATE_W-1:0] g);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= req;
        req_if.event_time <= t;
        req_if.gate_index <= g;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic sender_gap(input int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] t;
        logic [GATE_W-1:0] g;
        int                add_pct;
        int                roll;
        int                idx;
        int                seg;

        tracker = new();
        idle_on = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_ADD;
        req_if.event_time = '0;
        req_if.gate_index = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list corner cases
        send_item(REQ_PROBE, '0, '0);
        send_item(REQ_CANCEL, '0, '0);
        send_item(REQ_ARRIVE, NO_TIME, 8'hff);
        // an all-ones time looks like an empty head, list_empty tells them apart
        send_item(REQ_ADD, NO_TIME, 8'hff);
        send_item(REQ_PROBE, NO_TIME, 8'h00);
        // equal times: the later add sits ahead
        send_item(REQ_ADD, '0, 8'h00);
        send_item(REQ_ADD, '0, 8'h01);
        send_item(REQ_PROBE, 64'd1, 8'h00);
        send_item(REQ_CANCEL, '0, 8'h00);
        send_item(REQ_CANCEL, 64'd5, 8'h00);
        send_item(REQ_ARRIVE, '0, 8'h01);
        // arrival ahead of its sync point still removes it
        send_item(REQ_ADD, 64'd100, 8'h03);
        send_item(REQ_ARRIVE, 64'd50, 8'h03);
        send_item(REQ_ARRIVE, NO_TIME, 8'h07);
        // fill to the brim, then one add too many
        for (int i = 0; i < LIST_DEPTH - 1; i++)
            send_item(REQ_ADD, pick_time(), GATE_W'(i));
        send_item(REQ_ADD, 64'h5555_aaaa_5555_aaaa, 8'haa);
        send_item(REQ_PROBE, 64'haaaa_5555_aaaa_5555, 8'h55);

        // random: segments alternate between filling, balanced and draining
        for (int n = 0; n < 1050; n++) begin
            seg = n / 75;
            if (n % 75 == 0) begin
                idle_on = (seg % 4 != 3) && (seg < 12);
                if (seg == 2) hold_off_req = 1'b1;
            end
            case (seg % 3)
                0: add_pct = 70;
                1: add_pct = 40;
                default: add_pct = 20;
            endcase

            t = pick_time();
            g = pick_gate();
            roll = $urandom_range(0, 99);
            if (roll < add_pct) begin
                req = REQ_ADD;
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 4) req = REQ_ARRIVE;
                else if (roll < 7) req = REQ_CANCEL;
                else req = REQ_PROBE;
            end

            // removals mostly target stored entries so they get past the search
            if (tracker.slot_times.size() > 0 && $urandom_range(0, 3) != 0) begin
                idx = $urandom_range(0, tracker.slot_times.size() - 1);
                if (req == REQ_CANCEL) begin
                    t = tracker.slot_times[idx];
                    g = tracker.slot_gates[idx];
                end else if (req == REQ_ARRIVE) begin
                    g = tracker.slot_gates[idx];
                    case ($urandom_range(0, 3))
                        0: t = tracker.slot_times[idx];
                        1: t = tracker.slot_times[idx] - 1;
                        2: t = tracker.slot_times[idx] + 1;
                        default: ;
                    endcase
                end else if (req == REQ_PROBE) begin
                    t = tracker.earliest_time() + TIME_W'($urandom_range(0, 2)) - 1;
                end
            end

            if (idle_on && $urandom_range(0, 7) == 0)
                sender_gap($urandom_range(1, 17));
            send_item(req, t, g);
        end
        req_if.valid <= 1'b0;

        // drain, then a few cycles for anything stray
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
